// File: sv/bat_pkg.sv
// shared constants, types and helpers for the buddy allocator tree unit
// no dependencies

package bat_pkg;

    // largest pool supported, log2 of units
    localparam int LOG_CAPACITY = 10;
    localparam int NODE_COUNT   = (2 << LOG_CAPACITY) - 1;
    localparam int ADDR_W       = LOG_CAPACITY + 1;
    // node code: 0 marks an allocated node, k+1 means largest free block is 2^k
    localparam int ENC_W        = $clog2(LOG_CAPACITY + 2);
    localparam int LVL_W        = ENC_W;

    localparam logic [ENC_W-1:0] ENC_USED = '0;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM    = 2'd1;
    localparam logic [1:0] STAT_BAD_OFFSET = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ROOT_CHK,
        ST_DOWN,
        ST_MARK,
        ST_UP,
        ST_SCAN,
        ST_DONE
    } bat_state_t;

    // log2 of amount rounded up, amount of zero gives 16
    function automatic logic [4:0] ceil_log2_16(input logic [15:0] amount);
        logic [15:0] m;
        logic [4:0]  r;
        m = amount - 16'd1;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (m[i])
            begin
                r = 5'(i + 1);
            end
        end
        return r;
    endfunction

    // index of the other child under the same parent
    function automatic logic [ADDR_W-1:0] sibling_of(input logic [ADDR_W-1:0] idx);
        return idx[0] ? idx + ADDR_W'(1) : idx - ADDR_W'(1);
    endfunction

endpackage

// File: sv/buddy_allocator_tree_unit.sv
// buddy allocator over a binary tree of free-block sizes kept in one memory
// depends on bat_pkg

// usage
// input channel: in_valid/in_ready carry one beat of operation, request_amount
//   and block_offset; output channel: out_valid/out_ready carry one beat of
//   status, result_offset and block_units for every input beat
// the tree lives in a 2047 x 4 memory with one read and one write port; a small
//   sequencer walks it one level per cycle, down for allocate and up for free
//   and query, with the parent refresh reusing the same compare/max unit
// order of work: allocate decodes, checks the root, walks down to the block's
//   level, marks that node and refreshes the parents up to the root; free scans up
//   to the allocated node, then refreshes up to the root; query scans up only;
//   rejects found at decode and an allocate the root cannot hold go to the result
// one item is in work at a time; in_ready is high only while the sequencer waits,
//   so the next beat is taken only once the sequencer is back from a result
// the result sits in an output register, so a new beat is taken while the
//   previous result is still stalled; the next result waits in the sequencer
//   until the receiver takes the one in front
// reset and every write of the pool size register start a clearing sweep over
//   all 2047 nodes, one node per cycle, during which no beat is accepted
// cfg_write_data above the capacity saturates to 10

module buddy_allocator_tree_unit
    import bat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] request_amount,
    input  logic [9:0]  block_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [9:0]  result_offset,
    output logic [10:0] block_units,
    input  logic        cfg_write_en,
    input  logic [3:0]  cfg_write_data
);

    // control state
    bat_state_t          state_reg, state_next;
    logic [3:0]          pool_log_reg, pool_log_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [4:0]          clr_level_reg, clr_level_next;
    logic                out_valid_reg, out_valid_next;

    // item in work
    logic [1:0]          op_reg, op_next;
    logic [4:0]          lg_reg, lg_next;
    logic                amount_zero_reg, amount_zero_next;
    logic [9:0]          offset_reg, offset_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [ENC_W-1:0]    cur_enc_reg, cur_enc_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [9:0]          res_offset_reg, res_offset_next;
    logic [10:0]         res_units_reg, res_units_next;

    // output register
    logic [1:0]          status_reg, status_next;
    logic [9:0]          result_offset_reg, result_offset_next;
    logic [10:0]         block_units_reg, block_units_next;

    // tree memory
    logic [ENC_W-1:0]    tree_mem [0:NODE_COUNT-1];
    logic [ENC_W-1:0]    rd_data_reg;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [ENC_W-1:0]    mem_wr_data;

    // shared decisions
    logic                accept;
    logic                out_free;
    logic [3:0]          cfg_sat;
    logic [ADDR_W-1:0]   pool_units;
    logic [ADDR_W-1:0]   leaf_idx;
    logic                alloc_bad;
    logic                offset_bad;
    logic                root_fail;
    logic                node_used;
    logic [ADDR_W-1:0]   left_idx;
    logic [ADDR_W-1:0]   down_idx;
    logic                down_last;
    logic [ADDR_W-1:0]   parent_idx;
    logic [LVL_W-1:0]    level_up;
    logic [ENC_W-1:0]    left_enc;
    logic [ENC_W-1:0]    right_enc;
    logic                merge;
    logic [ENC_W-1:0]    up_enc;
    logic [ADDR_W:0]     alloc_span;
    logic                clr_dec;
    logic [4:0]          clr_lvl;
    logic                clr_last;

    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign cfg_sat    = (cfg_write_data > 4'(LOG_CAPACITY)) ? 4'(LOG_CAPACITY)
                                                            : cfg_write_data;
    assign pool_units = ADDR_W'(1) << pool_log_reg;
    assign leaf_idx   = pool_units - ADDR_W'(1) + ADDR_W'(offset_reg);
    assign alloc_bad  = amount_zero_reg || (lg_reg > {1'b0, pool_log_reg});
    assign offset_bad = ({1'b0, offset_reg} >= pool_units);
    assign root_fail  = ({1'b0, rd_data_reg} < (lg_reg + 5'd1));
    assign node_used  = (rd_data_reg == ENC_USED);

    // walk down: take the left child when it can hold the request
    assign left_idx   = {idx_reg[ADDR_W-2:0], 1'b1};
    assign down_idx   = ({1'b0, rd_data_reg} >= (lg_reg + 5'd1)) ? left_idx
                                                                 : left_idx + ADDR_W'(1);
    assign down_last  = ((level_reg - LVL_W'(1)) == LVL_W'(lg_reg));

    // walk up: refresh parent from the node just written and its sibling
    assign parent_idx = (idx_reg - ADDR_W'(1)) >> 1;
    assign level_up   = level_reg + LVL_W'(1);
    assign left_enc   = idx_reg[0] ? cur_enc_reg : rd_data_reg;
    assign right_enc  = idx_reg[0] ? rd_data_reg : cur_enc_reg;
    // two fully free halves join into one free block on release
    assign merge      = (op_reg == OP_FREE) && (left_enc == right_enc)
                        && (left_enc == ENC_W'(level_up));
    assign up_enc     = merge ? ENC_W'(level_up) + ENC_W'(1)
                              : ((left_enc > right_enc) ? left_enc : right_enc);

    // block start: (idx + 1) * 2^lg - pool
    assign alloc_span = ((ADDR_W+1)'(idx_reg) + (ADDR_W+1)'(1)) << lg_reg[3:0];

    // clearing sweep, level drops at the first node of each depth
    assign clr_dec    = (((clr_cnt_reg + ADDR_W'(1)) & clr_cnt_reg) == '0);
    assign clr_lvl    = clr_level_reg - {4'd0, clr_dec};
    assign clr_last   = (clr_cnt_reg == ADDR_W'(NODE_COUNT - 1));

    assign in_ready   = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    state_next = alloc_bad ? ST_DONE : ST_ROOT_CHK;
                end
                else if (op_reg == OP_FREE || op_reg == OP_QUERY)
                begin
                    state_next = offset_bad ? ST_DONE : ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ROOT_CHK:
            begin
                if (root_fail)
                begin
                    state_next = ST_DONE;
                end
                else if (pool_log_reg == lg_reg[3:0])
                begin
                    state_next = ST_MARK;
                end
                else
                begin
                    state_next = ST_DOWN;
                end
            end
            ST_DOWN:
            begin
                if (down_last)
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                state_next = (idx_reg == '0) ? ST_DONE : ST_UP;
            end
            ST_UP:
            begin
                if (parent_idx == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (node_used)
                begin
                    if (op_reg == OP_QUERY || idx_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_UP;
                    end
                end
                else if (idx_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        // a pool size write restarts the sweep
        if (cfg_write_en)
        begin
            state_next = ST_CLEAR;
        end
    end

    // datapath and memory controls
    always_comb
    begin
        pool_log_next      = pool_log_reg;
        clr_cnt_next       = clr_cnt_reg;
        clr_level_next     = clr_level_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        op_next            = op_reg;
        lg_next            = lg_reg;
        amount_zero_next   = amount_zero_reg;
        offset_next        = offset_reg;
        idx_next           = idx_reg;
        level_next         = level_reg;
        cur_enc_next       = cur_enc_reg;
        res_status_next    = res_status_reg;
        res_offset_next    = res_offset_reg;
        res_units_next     = res_units_reg;
        status_next        = status_reg;
        result_offset_next = result_offset_reg;
        block_units_next   = block_units_reg;
        mem_rd_addr        = idx_reg;
        mem_wr_en          = 1'b0;
        mem_wr_addr        = idx_reg;
        mem_wr_data        = ENC_USED;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en      = 1'b1;
                mem_wr_addr    = clr_cnt_reg;
                mem_wr_data    = ENC_W'(clr_lvl + 5'd1);
                clr_cnt_next   = clr_cnt_reg + ADDR_W'(1);
                clr_level_next = clr_lvl;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next          = operation;
                    lg_next          = ceil_log2_16(request_amount);
                    amount_zero_next = (request_amount == '0);
                    offset_next      = block_offset;
                end
            end
            ST_DECODE:
            begin
                res_status_next = STAT_OK;
                res_offset_next = '0;
                res_units_next  = '0;
                if (op_reg == OP_ALLOC)
                begin
                    mem_rd_addr = '0;
                    if (alloc_bad)
                    begin
                        res_status_next = STAT_NO_ROOM;
                    end
                end
                else if (op_reg == OP_FREE || op_reg == OP_QUERY)
                begin
                    idx_next    = leaf_idx;
                    level_next  = '0;
                    mem_rd_addr = leaf_idx;
                    if (offset_bad)
                    begin
                        res_status_next = STAT_BAD_OFFSET;
                    end
                end
                else
                begin
                    res_status_next = STAT_NO_ROOM;
                end
            end
            ST_ROOT_CHK:
            begin
                idx_next    = '0;
                level_next  = LVL_W'(pool_log_reg);
                mem_rd_addr = ADDR_W'(1);
                if (root_fail)
                begin
                    res_status_next = STAT_NO_ROOM;
                end
            end
            ST_DOWN:
            begin
                idx_next    = down_idx;
                level_next  = level_reg - LVL_W'(1);
                mem_rd_addr = {down_idx[ADDR_W-2:0], 1'b1};
            end
            ST_MARK:
            begin
                mem_wr_en       = 1'b1;
                mem_wr_addr     = idx_reg;
                mem_wr_data     = ENC_USED;
                cur_enc_next    = ENC_USED;
                mem_rd_addr     = sibling_of(idx_reg);
                res_offset_next = 10'(alloc_span - (ADDR_W+1)'(pool_units));
                res_units_next  = 11'd1 << lg_reg[3:0];
            end
            ST_UP:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = parent_idx;
                mem_wr_data  = up_enc;
                cur_enc_next = up_enc;
                idx_next     = parent_idx;
                level_next   = level_up;
                mem_rd_addr  = sibling_of(parent_idx);
            end
            ST_SCAN:
            begin
                if (node_used)
                begin
                    if (op_reg == OP_QUERY)
                    begin
                        res_units_next = 11'd1 << level_reg;
                    end
                    else
                    begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = idx_reg;
                        mem_wr_data  = ENC_W'(level_reg) + ENC_W'(1);
                        cur_enc_next = ENC_W'(level_reg) + ENC_W'(1);
                        mem_rd_addr  = sibling_of(idx_reg);
                    end
                end
                else if (idx_reg != '0)
                begin
                    idx_next    = parent_idx;
                    level_next  = level_up;
                    mem_rd_addr = parent_idx;
                end
                else
                begin
                    res_status_next = STAT_BAD_OFFSET;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = res_status_reg;
                    result_offset_next = res_offset_reg;
                    block_units_next   = res_units_reg;
                end
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase

        if (cfg_write_en)
        begin
            pool_log_next  = cfg_sat;
            clr_cnt_next   = '0;
            clr_level_next = {1'b0, cfg_sat} + 5'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pool_log_reg  <= 4'(LOG_CAPACITY);
            clr_cnt_reg   <= '0;
            clr_level_reg <= 5'(LOG_CAPACITY + 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_log_reg  <= pool_log_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_level_reg <= clr_level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        lg_reg            <= lg_next;
        amount_zero_reg   <= amount_zero_next;
        offset_reg        <= offset_next;
        idx_reg           <= idx_next;
        level_reg         <= level_next;
        cur_enc_reg       <= cur_enc_next;
        res_status_reg    <= res_status_next;
        res_offset_reg    <= res_offset_next;
        res_units_reg     <= res_units_next;
        status_reg        <= status_next;
        result_offset_reg <= result_offset_next;
        block_units_reg   <= block_units_next;
    end

    // tree memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            tree_mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_data_reg <= tree_mem[mem_rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign result_offset = result_offset_reg;
    assign block_units   = block_units_reg;

    // checks

    // a pool size write always closes intake as the sweep starts
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> !in_ready)
        else $error("intake open right after pool size write");

    // failures carry no offset and no size
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (result_offset == '0 && block_units == '0))
        else $error("failed result carries payload");

    // memory writes stay inside the node array
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (mem_wr_addr < ADDR_W'(NODE_COUNT)))
        else $error("tree write out of range");

    // tree walks never climb above the root level of the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP || state_reg == ST_SCAN) |-> (level_reg <= LVL_W'(pool_log_reg)))
        else $error("walk level beyond pool");

    // an accepted beat starts decoding next cycle unless a pool write intervenes
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_write_en) |=> (state_reg == ST_DECODE))
        else $error("accepted beat not decoded");

endmodule
